// File: src/qmd_pkg.sv
package qmd_pkg;

	// Constellation selection held in the mode register
	typedef logic [1:0] qmd_mode_t;

	localparam qmd_mode_t MODE_BPSK  = 2'd0;
	localparam qmd_mode_t MODE_QPSK  = 2'd1;
	localparam qmd_mode_t MODE_QAM16 = 2'd2;

	localparam int LABEL_WIDTH = 4;

	// Gray code of one 16-QAM axis level
	typedef logic [1:0] qmd_gray_t;

	localparam qmd_gray_t GRAY_M3 = 2'b00;
	localparam qmd_gray_t GRAY_M1 = 2'b01;
	localparam qmd_gray_t GRAY_P3 = 2'b10;
	localparam qmd_gray_t GRAY_P1 = 2'b11;

	// Per-stage load enables from the pipeline control
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} qmd_stage_en_t;

	// Decision for one axis
	typedef struct packed {
		qmd_gray_t code;    // nearest of the four 16-QAM levels
		logic      pos;     // +1 strictly nearer than -1
	} qmd_axis_dec_t;

endpackage

// File: src/qmd_sample_if.sv
interface qmd_sample_if #(
	parameter int SAMPLE_WIDTH = 16
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_i;
	logic signed [SAMPLE_WIDTH-1:0] sample_q;

	modport source(output valid, output sample_i, output sample_q, input ready);
	modport sink(input valid, input sample_i, input sample_q, output ready);
endinterface

// File: src/qmd_label_if.sv
interface qmd_label_if ();
	logic       valid;
	logic       ready;
	logic [3:0] label_bits;

	modport source(output valid, output label_bits, input ready);
	modport sink(input valid, input label_bits, output ready);
endinterface

// File: src/qmd_pipe_ctrl.sv
module qmd_pipe_ctrl import qmd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output qmd_stage_en_t en
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;

	// A stage loads when it is empty or its successor loads too
	always_comb begin
		en.en_s4 = !valid_s4 || out_ready;
		en.en_s3 = !valid_s3 || en.en_s4;
		en.en_s2 = !valid_s2 || en.en_s3;
		en.en_s1 = !valid_s1 || en.en_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.en_s1) valid_s1 <= in_valid;
			if (en.en_s2) valid_s2 <= valid_s1;
			if (en.en_s3) valid_s3 <= valid_s2;
			if (en.en_s4) valid_s4 <= valid_s3;
		end
	end

	assign in_ready  = en.en_s1;
	assign out_valid = valid_s4;

	a_bubble_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s4 |-> in_ready)
		else $error("input stalled with an empty output stage");

	a_no_invented_item: assert property (@(posedge clk) disable iff (!arst_n)
		en.en_s1 && !in_valid |=> !valid_s1)
		else $error("stage 1 filled without a transaction");

	a_mid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !en.en_s3 |=> valid_s2)
		else $error("stage 2 item lost while stage 3 stalled");

	a_s3_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && en.en_s4 |=> valid_s4)
		else $error("stage 3 item dropped on its way to output");

endmodule

// File: src/qmd_axis_slicer.sv
module qmd_axis_slicer import qmd_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int FRAC_BITS    = 12
) (
	input  logic                           clk,
	input  qmd_stage_en_t                  en,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output qmd_axis_dec_t                  dec_s4
);

	localparam int LVL_WIDTH = FRAC_BITS + 3;
	localparam int DW  = ((SAMPLE_WIDTH > LVL_WIDTH) ? SAMPLE_WIDTH : LVL_WIDTH) + 1;
	localparam int SQW = 2 * DW;

	localparam logic signed [DW-1:0] UNIT  = {{(DW-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic signed [DW-1:0] UNIT3 = UNIT + (UNIT <<< 1);

	logic signed [DW-1:0] s_ext;
	logic signed [DW-1:0] diff_s1 [4];    // indexed by Gray code
	logic [SQW-1:0]       sq_s2 [4];
	logic [SQW-1:0]       dist_a_s3, dist_b_s3;
	qmd_gray_t            code_a_s3, code_b_s3;
	logic                 pos_s3;

	assign s_ext = DW'(sample);

	// Stage 1: offsets to the four levels
	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			diff_s1[GRAY_M3] <= s_ext + UNIT3;
			diff_s1[GRAY_M1] <= s_ext + UNIT;
			diff_s1[GRAY_P3] <= s_ext - UNIT3;
			diff_s1[GRAY_P1] <= s_ext - UNIT;
		end
	end

	// Stage 2: square each offset
	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			for (int k = 0; k < 4; k++) begin
				sq_s2[k] <= $unsigned(SQW'(diff_s1[k]) * SQW'(diff_s1[k]));
			end
		end
	end

	// Stage 3: pairwise minimum, lower code keeps a tie
	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			if (sq_s2[GRAY_M1] < sq_s2[GRAY_M3]) begin
				dist_a_s3 <= sq_s2[GRAY_M1];
				code_a_s3 <= GRAY_M1;
			end else begin
				dist_a_s3 <= sq_s2[GRAY_M3];
				code_a_s3 <= GRAY_M3;
			end
			if (sq_s2[GRAY_P1] < sq_s2[GRAY_P3]) begin
				dist_b_s3 <= sq_s2[GRAY_P1];
				code_b_s3 <= GRAY_P1;
			end else begin
				dist_b_s3 <= sq_s2[GRAY_P3];
				code_b_s3 <= GRAY_P3;
			end
			pos_s3 <= sq_s2[GRAY_P1] < sq_s2[GRAY_M1];
		end
	end

	// Stage 4: final minimum
	always_ff @(posedge clk) begin
		if (en.en_s4) begin
			dec_s4.code <= (dist_b_s3 < dist_a_s3) ? code_b_s3 : code_a_s3;
			dec_s4.pos  <= pos_s3;
		end
	end

endmodule

// File: src/qam_min_distance_demapper.sv
// Hard-decision min-distance demapper for BPSK, QPSK and Gray 16-QAM.
// Each accepted sample moves through stages s1 to s4; its label is valid once s4 holds it.
// Throughput: one sample per cycle; the four register stages each take a new
// item whenever the stage after them loads, so backpressure only stalls a full pipe.
// Reset (arst_n low, asynchronous): all stage valid bits clear and the mode
// register returns to BPSK; payload registers are not reset.
module qam_min_distance_demapper import qmd_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int FRAC_BITS    = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	qmd_sample_if.sink    samples,
	qmd_label_if.source   labels,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_wdata
);

	qmd_mode_t     mode_q;
	qmd_stage_en_t en;
	qmd_axis_dec_t dec_i_s4, dec_q_s4;
	logic          out_valid;

	// Mode register; software writes it only while the pipe is drained (a rule for
	// software that the block does not enforce), as the label assembly reads it directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BPSK;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Valid bits and stage enables: a stage advances when it is empty or
	// the downstream stage advances; hold otherwise.
	qmd_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (out_valid),
		.out_ready (labels.ready),
		.en        (en)
	);

	// The squared distance splits into an I term and a Q term, and the
	// points form a grid, so the nearest point (with the smaller label on
	// a tie) is the per-axis nearest level with the lower code on a tie.
	qmd_axis_slicer #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.FRAC_BITS    (FRAC_BITS)
	) u_slice_i (
		.clk    (clk),
		.en     (en),
		.sample (samples.sample_i),
		.dec_s4 (dec_i_s4)
	);

	qmd_axis_slicer #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.FRAC_BITS    (FRAC_BITS)
	) u_slice_q (
		.clk    (clk),
		.en     (en),
		.sample (samples.sample_q),
		.dec_s4 (dec_q_s4)
	);

	// Assemble the right-aligned label from the registered axis decisions.
	// BPSK ignores Q entirely (both points sit on the I axis); the spare
	// mode code decodes as 16-QAM.
	always_comb begin
		priority if (mode_q == MODE_BPSK) begin
			labels.label_bits = {3'b000, dec_i_s4.pos};
		end else if (mode_q == MODE_QPSK) begin
			labels.label_bits = {2'b00, dec_i_s4.pos, dec_q_s4.pos};
		end else begin
			labels.label_bits = {dec_i_s4.code, dec_q_s4.code};
		end
	end

	assign labels.valid = out_valid;

endmodule
